// ===== rtl/core/wmss_pkg.sv =====
// Shared constants, types and sequencer states of the windowed market state scorer.
`default_nettype none
package wmss_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int NUM_INST   = 16;
  localparam int INST_W     = 4;
  localparam int ADDR_W     = INST_W + SLOT_W;
  localparam int MEM_DEPTH  = NUM_INST * MAX_WINDOW;
  localparam int CNT_W      = 7;
  localparam int PRICE_W    = 40;
  localparam int VOL_W      = 48;
  localparam int SIZE_W     = 32;
  localparam int TS_W       = 64;
  localparam int SCORE_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int SUM_W      = PRICE_W + SLOT_W;

  localparam int MUL_A_W    = 48;
  localparam int MUL_B_W    = 96;
  localparam int CHUNK_W    = 24;
  localparam int ACC_W      = 96;
  localparam int STEP_W     = 3;
  localparam int SHAMT_W    = 7;

  localparam int DIV_W      = 94;
  localparam int QUO_W      = 32;
  localparam int ITER_W     = 6;

  localparam int ROOT_W     = 16;
  localparam int SQREM_W    = 20;

  localparam logic [SCORE_W-1:0] SCORE_POS_MAX = 16'h7FFF;
  localparam logic [SCORE_W-1:0] SCORE_NEG_MAX = 16'h8000;
  localparam logic [SCORE_W-1:0] SCORE_U_MAX   = 16'hFFFF;

  typedef struct packed {
    logic              start;
    logic              clear;
    logic [STEP_W-1:0] steps;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PUSH, ST_PREP, ST_LOAD, ST_SQ,
    ST_NQ, ST_NQ_W, ST_S2, ST_S2_W, ST_D2, ST_D2_W,
    ST_VCHK, ST_DV, ST_DV_W, ST_SQRT, ST_SQRT_W,
    ST_TR, ST_TR_W, ST_LQ, ST_LQ_W, ST_SN, ST_SN_W, ST_OUT
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/core/wmss_mul.sv =====
// Shared multiply-accumulate unit that consumes one 24-bit chunk of its second operand a cycle.
`default_nettype none
module wmss_mul (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wmss_pkg::mul_req_t          req_i,
  input  wire [wmss_pkg::MUL_A_W-1:0] a_i,
  input  wire [wmss_pkg::MUL_B_W-1:0] b_i,
  output logic                        busy_o,
  output logic [wmss_pkg::ACC_W-1:0]  acc_o
);
  import wmss_pkg::*;

  logic [STEP_W-1:0]          cnt_q;
  logic [1:0]                 idx_q;
  logic [MUL_A_W-1:0]         a_q;
  logic [MUL_B_W-1:0]         b_q;
  logic [ACC_W-1:0]           acc_q;
  logic [MUL_A_W+CHUNK_W-1:0] prod;
  logic [SHAMT_W-1:0]         shamt;
  logic [ACC_W-1:0]           term;

  assign prod   = a_q * b_q[CHUNK_W-1:0];
  assign shamt  = SHAMT_W'(idx_q) * SHAMT_W'(CHUNK_W);
  assign term   = ACC_W'(prod) << shamt;
  assign busy_o = (cnt_q != '0);
  assign acc_o  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= req_i.steps;
      idx_q <= '0;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - STEP_W'(1);
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= a_i;
      b_q <= b_i;
      if (req_i.clear) begin
        acc_q <= '0;
      end
    end else if (cnt_q != '0) begin
      acc_q <= acc_q + term;
      b_q   <= b_q >> CHUNK_W;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wmss_div.sv =====
// Shared restoring divider that produces one quotient bit a cycle for a numerator below the divisor.
`default_nettype none
module wmss_div (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wmss_pkg::div_req_t         req_i,
  input  wire [wmss_pkg::DIV_W-1:0]  num_i,
  input  wire [wmss_pkg::DIV_W-1:0]  den_i,
  output logic                       busy_o,
  output logic [wmss_pkg::QUO_W-1:0] quo_o
);
  import wmss_pkg::*;

  logic [ITER_W-1:0] cnt_q;
  logic [DIV_W-1:0]  rem_q;
  logic [DIV_W-1:0]  den_q;
  logic [QUO_W-1:0]  quo_q;
  logic [DIV_W:0]    sh;
  logic [DIV_W:0]    diff;
  logic              ge;

  assign sh     = {rem_q, 1'b0};
  assign ge     = (sh >= {1'b0, den_q});
  assign diff   = sh - {1'b0, den_q};
  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= req_i.iters;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - ITER_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wmss_sqrt.sv =====
// Digit-by-digit integer square root of a 32-bit word, one root bit a cycle.
`default_nettype none
module wmss_sqrt (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  wire [wmss_pkg::QUO_W-1:0]   x_i,
  output logic                        busy_o,
  output logic [wmss_pkg::ROOT_W-1:0] root_o
);
  import wmss_pkg::*;

  localparam int CNT_SW = $clog2(ROOT_W + 1);

  logic [CNT_SW-1:0]  cnt_q;
  logic [QUO_W-1:0]   x_q;
  logic [SQREM_W-1:0] rem_q;
  logic [ROOT_W-1:0]  root_q;
  logic [SQREM_W-1:0] r;
  logic [SQREM_W-1:0] trial;
  logic               ge;

  assign r      = {rem_q[SQREM_W-3:0], x_q[QUO_W-1:QUO_W-2]};
  assign trial  = SQREM_W'({root_q, 2'b01});
  assign ge     = (r >= trial);
  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_SW'(ROOT_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNT_SW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      x_q    <= x_q << 2;
      rem_q  <= ge ? (r - trial) : r;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/windowed_market_state_scorer_unit.sv =====
// Top level of the windowed market state scorer: window rings, sequencer and score registers.
// The work on each accepted word grows with n, the entries held in its window: the window walk
// visits each entry, then the serial divider and square root do most of the rest; when n is 1 no
// score is computed. Saturated scores skip their division. The next word is taken in the cycle
// after the result is loaded; in_stall_o holds off new words until then.
// Reset clears the fill counts and pointers, sets the window length to 64, leaves the rings as is.
`default_nettype none
module windowed_market_state_scorer_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [wmss_pkg::CNT_W-1:0]    cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [wmss_pkg::INST_W-1:0]   instrument_i,
  input  wire [wmss_pkg::TS_W-1:0]     timestamp_i,
  input  wire [wmss_pkg::PRICE_W-1:0]  last_price_i,
  input  wire [wmss_pkg::VOL_W-1:0]    cumulative_volume_i,
  input  wire [wmss_pkg::PRICE_W-1:0]  best_bid_price_i,
  input  wire [wmss_pkg::PRICE_W-1:0]  best_ask_price_i,
  input  wire [wmss_pkg::SIZE_W-1:0]   best_bid_size_i,
  input  wire [wmss_pkg::SIZE_W-1:0]   best_ask_size_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [wmss_pkg::INST_W-1:0]  instrument_out_o,
  output logic [wmss_pkg::TS_W-1:0]    timestamp_out_o,
  output logic [wmss_pkg::PRICE_W-1:0] window_open_o,
  output logic [wmss_pkg::PRICE_W-1:0] window_high_o,
  output logic [wmss_pkg::PRICE_W-1:0] window_low_o,
  output logic [wmss_pkg::PRICE_W-1:0] window_close_o,
  output logic [wmss_pkg::VOL_W-1:0]   volume_change_o,
  output logic                         bar_valid_o,
  output logic signed [wmss_pkg::SCORE_W-1:0] trend_score_o,
  output logic [wmss_pkg::SCORE_W-1:0] volatility_score_o,
  output logic [wmss_pkg::SCORE_W-1:0] liquidity_score_o,
  output logic signed [wmss_pkg::SCORE_W-1:0] sentiment_score_o
);
  import wmss_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0]   wl_q;
  logic [CNT_W-1:0]   fill_q [NUM_INST];
  logic [SLOT_W-1:0]  wp_q   [NUM_INST];

  logic [INST_W-1:0]  inst_q;
  logic [TS_W-1:0]    ts_q;
  logic [PRICE_W-1:0] price_q, bid_q, ask_q;
  logic [VOL_W-1:0]   vol_q;
  logic [SIZE_W-1:0]  bsz_q, asz_q;

  logic [CNT_W-1:0]   n_q, k_q;
  logic [SLOT_W-1:0]  wpn_q;
  logic [PRICE_W-1:0] first_q, hi_q, lo_q;
  logic [VOL_W-1:0]   vfirst_q;
  logic [SUM_W-1:0]   s_q;
  logic [DIV_W-1:0]   v_q, d2_q;
  logic [SCORE_W-1:0] trend_q, volat_q, liq_q, sent_q;

  logic [PRICE_W-1:0] pmem [MEM_DEPTH];
  logic [VOL_W-1:0]   vmem [MEM_DEPTH];
  logic [PRICE_W-1:0] pmem_q;
  logic [VOL_W-1:0]   vmem_q;

  logic               out_valid_q;
  logic               out_load;

  logic [CNT_W-1:0]   len;
  logic [CNT_W-1:0]   fill_inc;
  logic [CNT_W-1:0]   n_push;
  logic [SLOT_W-1:0]  slot_cur;
  logic [SLOT_W-1:0]  rd_slot;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic               mem_we;

  logic [MUL_A_W-1:0] n_unit;
  logic [MUL_A_W-1:0] d_val;
  logic               t_up, t_sat;
  logic [PRICE_W-1:0] t_diff;
  logic [PRICE_W-1:0] spread;
  logic [PRICE_W:0]   liq_den;
  logic [SIZE_W+1:0]  s_den;
  logic               s_up;
  logic [SIZE_W-1:0]  s_diff;
  logic               walk_done;

  mul_req_t           mul_req;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_busy;
  logic [ACC_W-1:0]   mul_acc;

  div_req_t           div_req;
  logic [DIV_W-1:0]   div_num, div_den;
  logic               div_busy;
  logic [QUO_W-1:0]   div_quo;

  logic               sq_start;
  logic               sq_busy;
  logic [ROOT_W-1:0]  sq_root;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);

  assign len      = (wl_q == '0) ? CNT_W'(1) :
                    (wl_q > CNT_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : wl_q;
  assign slot_cur = wp_q[inst_q];
  assign fill_inc = fill_q[inst_q] + CNT_W'(1);
  assign n_push   = (fill_inc > len) ? len : fill_inc;
  assign rd_slot  = wpn_q - n_q[SLOT_W-1:0] + k_q[SLOT_W-1:0];
  assign wr_addr  = {inst_q, slot_cur};
  assign rd_addr  = {inst_q, rd_slot};
  assign mem_we   = (state_q == ST_PUSH);

  assign n_unit   = MUL_A_W'(n_q) << FRAC_W;
  assign d_val    = (MUL_A_W'(s_q) >= n_unit) ? MUL_A_W'(s_q) : n_unit;
  assign t_up     = (price_q >= first_q);
  assign t_diff   = t_up ? (price_q - first_q) : (first_q - price_q);
  assign t_sat    = (t_diff >= first_q);
  assign spread   = (ask_q > bid_q) ? (ask_q - bid_q) : '0;
  assign liq_den  = (PRICE_W+1)'(spread) + ((PRICE_W+1)'(1) << FRAC_W);
  assign s_den    = (SIZE_W+2)'(bsz_q) + (SIZE_W+2)'(asz_q) + (SIZE_W+2)'(1);
  assign s_up     = (bsz_q >= asz_q);
  assign s_diff   = s_up ? (bsz_q - asz_q) : (asz_q - bsz_q);
  assign walk_done = (k_q == n_q);
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pmem[wr_addr] <= price_q;
      vmem[wr_addr] <= vol_q;
    end
    pmem_q <= pmem[rd_addr];
    vmem_q <= vmem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_PUSH;
      ST_PUSH:   state_d = ST_PREP;
      ST_PREP:   state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_SQ;
      ST_SQ: begin
        if (!mul_busy) begin
          if (!walk_done) state_d = ST_LOAD;
          else if (n_q >= CNT_W'(2)) state_d = ST_NQ;
          else state_d = ST_OUT;
        end
      end
      ST_NQ:     state_d = ST_NQ_W;
      ST_NQ_W:   if (!mul_busy) state_d = ST_S2;
      ST_S2:     state_d = ST_S2_W;
      ST_S2_W:   if (!mul_busy) state_d = ST_D2;
      ST_D2:     state_d = ST_D2_W;
      ST_D2_W:   if (!mul_busy) state_d = ST_VCHK;
      ST_VCHK:   state_d = (v_q >= d2_q) ? ST_TR : ST_DV;
      ST_DV:     state_d = ST_DV_W;
      ST_DV_W:   if (!div_busy) state_d = ST_SQRT;
      ST_SQRT:   state_d = ST_SQRT_W;
      ST_SQRT_W: if (!sq_busy) state_d = ST_TR;
      ST_TR:     state_d = ((first_q == '0) || t_sat) ? ST_LQ : ST_TR_W;
      ST_TR_W:   if (!div_busy) state_d = ST_LQ;
      ST_LQ:     state_d = (spread == '0) ? ST_SN : ST_LQ_W;
      ST_LQ_W:   if (!div_busy) state_d = ST_SN;
      ST_SN:     state_d = ST_SN_W;
      ST_SN_W:   if (!div_busy) state_d = ST_OUT;
      ST_OUT:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_req  = '0;
    mul_a    = '0;
    mul_b    = '0;
    div_req  = '0;
    div_num  = '0;
    div_den  = '0;
    sq_start = 1'b0;
    case (state_q)
      ST_LOAD: begin
        mul_req = '{start: 1'b1, clear: (k_q == '0), steps: STEP_W'(2)};
        mul_a   = MUL_A_W'(pmem_q);
        mul_b   = MUL_B_W'(pmem_q);
      end
      ST_NQ: begin
        mul_req = '{start: 1'b1, clear: 1'b1, steps: STEP_W'(4)};
        mul_a   = MUL_A_W'(n_q);
        mul_b   = mul_acc;
      end
      ST_S2: begin
        mul_req = '{start: 1'b1, clear: 1'b1, steps: STEP_W'(2)};
        mul_a   = MUL_A_W'(s_q);
        mul_b   = MUL_B_W'(s_q);
      end
      ST_D2: begin
        mul_req = '{start: 1'b1, clear: 1'b1, steps: STEP_W'(2)};
        mul_a   = d_val;
        mul_b   = MUL_B_W'(d_val);
      end
      ST_DV: begin
        div_req = '{start: 1'b1, iters: ITER_W'(QUO_W)};
        div_num = v_q;
        div_den = d2_q;
      end
      ST_SQRT: begin
        sq_start = 1'b1;
      end
      ST_TR: begin
        div_req = '{start: (first_q != '0) && !t_sat, iters: ITER_W'(15)};
        div_num = DIV_W'(t_diff);
        div_den = DIV_W'(first_q);
      end
      ST_LQ: begin
        div_req = '{start: (spread != '0), iters: ITER_W'(16)};
        div_num = DIV_W'(1) << FRAC_W;
        div_den = DIV_W'(liq_den);
      end
      ST_SN: begin
        div_req = '{start: 1'b1, iters: ITER_W'(15)};
        div_num = DIV_W'(s_diff);
        div_den = DIV_W'(s_den);
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wl_q        <= CNT_W'(MAX_WINDOW);
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_INST; i++) begin
        fill_q[i] <= '0;
        wp_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        wl_q <= cfg_data_i;
      end
      if (state_q == ST_PUSH) begin
        fill_q[inst_q] <= n_push;
        wp_q[inst_q]   <= slot_cur + SLOT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          inst_q  <= instrument_i;
          ts_q    <= timestamp_i;
          price_q <= last_price_i;
          vol_q   <= cumulative_volume_i;
          bid_q   <= best_bid_price_i;
          ask_q   <= best_ask_price_i;
          bsz_q   <= best_bid_size_i;
          asz_q   <= best_ask_size_i;
        end
      end
      ST_PUSH: begin
        n_q     <= n_push;
        wpn_q   <= slot_cur + SLOT_W'(1);
        k_q     <= '0;
        trend_q <= '0;
        volat_q <= '0;
        liq_q   <= '0;
        sent_q  <= '0;
      end
      ST_LOAD: begin
        k_q <= k_q + CNT_W'(1);
        if (k_q == '0) begin
          first_q  <= pmem_q;
          hi_q     <= pmem_q;
          lo_q     <= pmem_q;
          s_q      <= SUM_W'(pmem_q);
          vfirst_q <= vmem_q;
        end else begin
          if (pmem_q > hi_q) hi_q <= pmem_q;
          if (pmem_q < lo_q) lo_q <= pmem_q;
          s_q <= s_q + SUM_W'(pmem_q);
        end
      end
      ST_NQ_W: if (!mul_busy) v_q <= mul_acc[DIV_W-1:0];
      ST_S2_W: if (!mul_busy) v_q <= v_q - mul_acc[DIV_W-1:0];
      ST_D2_W: if (!mul_busy) d2_q <= mul_acc[DIV_W-1:0];
      ST_VCHK: if (v_q >= d2_q) volat_q <= SCORE_U_MAX;
      ST_SQRT_W: if (!sq_busy) volat_q <= sq_root;
      ST_TR: begin
        if ((first_q != '0) && t_sat) begin
          trend_q <= t_up ? SCORE_POS_MAX : SCORE_NEG_MAX;
        end
      end
      ST_TR_W: begin
        if (!div_busy) begin
          trend_q <= t_up ? div_quo[SCORE_W-1:0] : (SCORE_W'(0) - div_quo[SCORE_W-1:0]);
        end
      end
      ST_LQ: if (spread == '0) liq_q <= SCORE_U_MAX;
      ST_LQ_W: if (!div_busy) liq_q <= div_quo[SCORE_W-1:0];
      ST_SN_W: begin
        if (!div_busy) begin
          sent_q <= s_up ? div_quo[SCORE_W-1:0] : (SCORE_W'(0) - div_quo[SCORE_W-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      instrument_out_o   <= inst_q;
      timestamp_out_o    <= ts_q;
      window_open_o      <= first_q;
      window_high_o      <= hi_q;
      window_low_o       <= lo_q;
      window_close_o     <= price_q;
      bar_valid_o        <= (n_q >= CNT_W'(2));
      volume_change_o    <= ((n_q >= CNT_W'(2)) && (vol_q > vfirst_q)) ? (vol_q - vfirst_q) : '0;
      trend_score_o      <= trend_q;
      volatility_score_o <= volat_q;
      liquidity_score_o  <= liq_q;
      sentiment_score_o  <= sent_q;
    end
  end

  assign out_valid_o = out_valid_q;

  wmss_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .busy_o (mul_busy),
    .acc_o  (mul_acc)
  );

  wmss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  wmss_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     (div_quo),
    .busy_o  (sq_busy),
    .root_o  (sq_root)
  );

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (k_q < n_q))
    else $error("Window walk index ran past the fill count.");

  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_busy)
    else $error("Multiplier started while busy.");

  a_fill_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) |=> ((n_q != '0) && (n_q <= CNT_W'(MAX_WINDOW))))
    else $error("Window fill count out of range.");

  a_short_window_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !bar_valid_o) |-> ((trend_score_o == '0) && (volatility_score_o == '0)
      && (liquidity_score_o == '0) && (sentiment_score_o == '0) && (volume_change_o == '0)))
    else $error("Scores set on a window with fewer than two entries.");

endmodule
`default_nettype wire
